// ===== hw/rtl/smavg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and control structs of the moving-average block.
package smavg_pkg;

  // Payload field widths.
  localparam int SAMPLE_W = 32;
  localparam int AVG_W    = 32;

  // Default sizing of the window store and the sample datapath.
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;

  // Register file: one 9-bit window length register.
  localparam int WL_W      = 9;
  localparam int WL_RESET  = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

  // One request: a sample and the start-of-series flag.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first_of_series;
  } smavg_req_t;

  // One result: the truncated window mean and its valid flag.
  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             valid_res;
  } smavg_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read_old;
    logic sub_old;
    logic add_new;
    logic div_start;
    logic div_step;
    logic out_load;
  } smavg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic out_free;
  } smavg_sts_t;

endpackage

// ===== hw/rtl/smavg_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the window length and its clamped effective value.
module smavg_regs #(
  parameter int WINDOW_MAX = smavg_pkg::WINDOW_MAX_DEF,
  parameter int LEN_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smavg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [smavg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [smavg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  output logic [LEN_W-1:0]                  len,
  output logic                              cfg_clear
);

  localparam int CW = (LEN_W > smavg_pkg::WL_W) ? LEN_W : smavg_pkg::WL_W;
  localparam int LEN_RST = (smavg_pkg::WL_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : smavg_pkg::WL_RESET;

  logic [smavg_pkg::WL_W-1:0] window_length;
  logic [smavg_pkg::WL_W-1:0] wl_new;
  logic [CW-1:0]              wl_ext;
  logic [LEN_W-1:0]           len_new;
  logic                       wr_en;

  // Write strobe for the window length register.
  assign wr_en = psel && penable && pwrite &&
                 (paddr[smavg_pkg::APB_ADDR_W-1:2] == smavg_pkg::REG_WINDOW_LENGTH);
  assign wl_new = pwdata[smavg_pkg::WL_W-1:0];
  assign wl_ext = CW'(wl_new);

  // Zero means one sample; anything above the store depth saturates.
  always_comb begin
    if (wl_ext == '0) begin
      len_new = LEN_W'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      len_new = LEN_W'(WINDOW_MAX);
    end else begin
      len_new = LEN_W'(wl_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= smavg_pkg::WL_W'(smavg_pkg::WL_RESET);
      len           <= LEN_W'(LEN_RST);
    end else if (wr_en) begin
      window_length <= wl_new;
      len           <= len_new;
    end
  end

  // A write to the window length also restarts the series.
  assign cfg_clear = wr_en;
  assign pready    = 1'b1;

  // Read back the register; other addresses read as zero.
  always_comb begin
    if (paddr[smavg_pkg::APB_ADDR_W-1:2] == smavg_pkg::REG_WINDOW_LENGTH) begin
      prdata = smavg_pkg::APB_DATA_W'(window_length);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== hw/rtl/smavg_dp.sv =====
`timescale 1ns / 1ps
// Datapath: sample ring, running sum, radix-2 divider and result register.
module smavg_dp #(
  parameter int WINDOW_MAX  = smavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = smavg_pkg::SAMPLE_BITS_DEF,
  parameter int LEN_W       = $clog2(WINDOW_MAX + 1),
  parameter int SMP_W       = (SAMPLE_BITS > smavg_pkg::SAMPLE_W) ? smavg_pkg::SAMPLE_W
                                                                  : SAMPLE_BITS,
  parameter int SUM_W       = SMP_W + $clog2(WINDOW_MAX)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smavg_pkg::smavg_cmd_t  cmd,
  output smavg_pkg::smavg_sts_t  sts,
  input  smavg_pkg::smavg_req_t  req_data,
  input  logic                   cfg_clear,
  input  logic [LEN_W-1:0]       len,
  output logic                   res_valid,
  input  logic                   res_ready,
  output smavg_pkg::smavg_res_t  res_data
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int A_W   = LEN_W + 1;

  logic [SMP_W-1:0] store [WINDOW_MAX];

  logic [PTR_W-1:0] ptr;
  logic [LEN_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [SMP_W-1:0] smp;
  logic [SMP_W-1:0] old;
  logic [LEN_W-1:0] rem;
  logic [SUM_W-1:0] quo;

  logic [A_W-1:0]   ptr_x;
  logic [A_W-1:0]   len_x;
  logic [A_W-1:0]   old_x;
  logic [PTR_W-1:0] old_idx;
  logic [LEN_W:0]   rem_sh;
  logic             rem_ge;
  logic             full;

  assign full = (count >= len);

  // Address of the sample that leaves the window.
  assign ptr_x   = A_W'(ptr);
  assign len_x   = A_W'(len);
  assign old_x   = (ptr_x >= len_x) ? (ptr_x - len_x)
                                    : (ptr_x + A_W'(WINDOW_MAX) - len_x);
  assign old_idx = old_x[PTR_W-1:0];

  // Sample ring: read the leaving sample, then write the new one.
  always_ff @(posedge clk) begin
    if (cmd.read_old) begin
      old <= store[old_idx];
    end
    if (cmd.add_new) begin
      store[ptr] <= smp;
    end
  end

  // Series state: pointer, fill count and running sum.
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      ptr   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.capture && req_data.first_of_series) begin
      ptr   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.sub_old) begin
      if (full) begin
        sum <= sum - SUM_W'(old);
      end
    end else if (cmd.add_new) begin
      sum <= sum + SUM_W'(smp);
      ptr <= (ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr + PTR_W'(1);
      if (!full) begin
        count <= count + LEN_W'(1);
      end
    end
  end

  // Captured sample, masked to the datapath width.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= req_data.sample[SMP_W-1:0];
    end
  end

  // Restoring divider: one quotient bit per step, sum shifts out MSB first.
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign rem_ge = (rem_sh >= (LEN_W + 1)'(len));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], rem_ge};
      rem <= rem_ge ? LEN_W'(rem_sh - (LEN_W + 1)'(len)) : rem_sh[LEN_W-1:0];
    end
  end

  // Result register, parting the datapath from the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_data.average   <= full ? smavg_pkg::AVG_W'(quo[SMP_W-1:0]) : '0;
      res_data.valid_res <= full;
    end
  end

  assign sts.full     = full;
  assign sts.out_free = !res_valid || res_ready;

  // The fill count never passes the window length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= len)
    else $error("fill count exceeds window length");

  // The write pointer stays inside the store.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr_x < A_W'(WINDOW_MAX))
    else $error("write pointer outside the store");

  // An empty window carries no sum.
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (sum == '0))
    else $error("nonzero sum with empty window");

  // A result is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res_valid || res_ready))
    else $error("result register overwritten");

endmodule

// ===== hw/rtl/smavg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences read, sum update, division and result hand-off.
module smavg_ctrl #(
  parameter int SUM_W = smavg_pkg::SAMPLE_BITS_DEF + $clog2(smavg_pkg::WINDOW_MAX_DEF)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output smavg_pkg::smavg_cmd_t  cmd,
  input  smavg_pkg::smavg_sts_t  sts
);

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUB,
    S_ADD,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  // State register and divider step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_READ;
        end
        S_READ:  state <= S_SUB;
        S_SUB:   state <= S_ADD;
        S_ADD:   state <= S_CHECK;
        S_CHECK: begin
          cnt   <= '0;
          state <= sts.full ? S_DIV : S_DONE;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_W - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.capture   = req_valid;
      S_READ:  cmd.read_old  = 1'b1;
      S_SUB:   cmd.sub_old   = 1'b1;
      S_ADD:   cmd.add_new   = 1'b1;
      S_CHECK: cmd.div_start = sts.full;
      S_DIV:   cmd.div_step  = 1'b1;
      S_DONE:  cmd.out_load  = sts.out_free;
      default: cmd = '0;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  // Division only runs on a full window.
  a_div_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> sts.full)
    else $error("division started on a window that is not full");

endmodule

// ===== hw/rtl/simple_moving_average.sv =====
`timescale 1ns / 1ps
// Top level of the simple moving average block.
// Each request carries one unsigned Q16.16 sample and a start-of-series flag and
// yields exactly one result: zero with valid_res clear until the window holds
// window_length samples, then the window mean rounded toward zero. With a full
// window, an accepted request passes the read, subtract, add and check states,
// then the radix-2 divider produces one quotient bit per cycle over the SUM_W-bit
// running sum before the result is loaded. While the window is still filling the
// divider is skipped. A new request is taken in the cycle after the previous one
// sits in the result register, so the block takes no new request while one is in
// flight; a stalled result register holds the block until it is free.
// The window length register lies at APB address 0; writing it restarts the
// series. Lengths of zero act as one and lengths above WINDOW_MAX saturate.
module simple_moving_average #(
  parameter int WINDOW_MAX  = smavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = smavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smavg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [smavg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [smavg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  smavg_pkg::smavg_req_t             req_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output smavg_pkg::smavg_res_t             res_data
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int SMP_W = (SAMPLE_BITS > smavg_pkg::SAMPLE_W) ? smavg_pkg::SAMPLE_W
                                                             : SAMPLE_BITS;
  localparam int SUM_W = SMP_W + $clog2(WINDOW_MAX);

  logic [LEN_W-1:0]      len;
  logic                  cfg_clear;
  smavg_pkg::smavg_cmd_t cmd;
  smavg_pkg::smavg_sts_t sts;

  // Configuration registers.
  smavg_regs #(
    .WINDOW_MAX (WINDOW_MAX),
    .LEN_W      (LEN_W)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .len       (len),
    .cfg_clear (cfg_clear)
  );

  // Sequencer.
  smavg_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Ring, sum, divider and result register.
  smavg_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .SMP_W       (SMP_W),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .cfg_clear (cfg_clear),
    .len       (len),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
